// File: src/lms_pkg.sv
// Shared types and constants for the 3x3 local maximum suppression block.
// Used by local_max_suppress_3x3; depends on nothing else.
`default_nettype none

package lms_pkg;

    localparam int PIXEL_W  = 8;
    localparam int WIN_SIZE = 9;
    localparam int WIN_CTR  = 4;

    typedef logic [PIXEL_W-1:0] t_pixel;
    typedef t_pixel t_win [WIN_SIZE];

    // Input item codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes (byte address is 4 times the index).
    typedef enum logic [1:0] {
        REG_PEAK_THRESHOLD = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT   = 2'd2
    } t_reg_idx;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int THRESH_W = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = 12;

    localparam logic [THRESH_W-1:0] THRESH_RST = 8'd50;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 11'd3;

endpackage

`default_nettype wire

// File: src/local_max_suppress_3x3.sv
// Streaming 3x3 local maximum suppression over a raster-order 8-bit image.
// Depends on lms_pkg for types, register indexes and command codes.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per pixel
//   (i_cmd = pixel) or a flush (i_cmd = flush) that drains one pending result.
//   Output channel (o_out_valid / i_out_stall) carries is_peak and frame_last
//   for pixels in raster order, one row plus one pixel behind the input.
//   Registers are written through the APB port (pready is always high) only
//   while idle, by the user (not enforced); a size write restarts the frame.
// Timing:
//   An accepted pixel reads both line buffers at the accept edge. Every
//   transaction is evaluated in the next cycle; a result is registered as
//   that stage advances. One transaction per clock is sustained while no
//   stall holds; each line buffer does one read and one write per cycle.
// Reset:
//   Synchronous reset clears the counters, the window, the pipeline and the
//   registers to their defaults. The line buffers are not swept: a pixel is
//   reported as interior only once its rows were written in this frame, so
//   old buffer contents never reach a result.
// Back pressure:
//   While the receiver stalls, the result holds in the output register and
//   transactions that produce no result keep passing the evaluation stage.
//   The first one that produces a result waits there, and o_in_stall stays
//   high until the output register frees up.
`default_nettype none

module local_max_suppress_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_cmd,
    input  wire  lms_pkg::t_pixel            i_pixel_value,
    // Output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_is_peak,
    output logic                             o_frame_last,
    // Configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [lms_pkg::ADDR_W-1:0]       paddr,
    input  wire  [lms_pkg::DATA_W-1:0]       pwdata,
    output logic [lms_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import lms_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    localparam int EFF_W_RST_I = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam logic [CW-1:0] EFF_W_RST = CW'(EFF_W_RST_I);
    localparam logic [CW-1:0] WM1_RST   = CW'(EFF_W_RST_I - 1);
    localparam logic [CW-1:0] WM2_RST   = CW'(EFF_W_RST_I - 2);
    localparam logic [ROW_W-1:0] HM1_RST = ROW_W'(1023);
    localparam logic [ROW_W-1:0] HM2_RST = ROW_W'(1022);

    // Configuration registers and their derived limits.
    logic [THRESH_W-1:0] r_thresh;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [CW-1:0]       r_eff_w;
    logic [CW-1:0]       r_wm1;
    logic [CW-1:0]       r_wm2;
    logic [ROW_W-1:0]    r_hm1;
    logic [ROW_W-1:0]    r_hm2;

    // Line buffers and their registered read data.
    t_pixel r_line_up  [MAX_WIDTH];
    t_pixel r_line_mid [MAX_WIDTH];
    t_pixel r_up_rd;
    t_pixel r_mid_rd;

    // Stream state.
    logic [AW-1:0]    r_col;
    logic [PW-1:0]    r_pending;
    logic [AW-1:0]    r_ecol;
    logic [ROW_W-1:0] r_erow;
    t_win             r_win;

    // Evaluation stage.
    logic          r_s1_valid;
    logic          r_s1_cmd;
    t_pixel        r_s1_px;
    logic [AW-1:0] r_s1_addr;

    // Output register.
    logic r_out_valid;
    logic r_out_peak;
    logic r_out_last;

    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic [CW-1:0]    n_eff_w;
    logic [HEIGHT_W-1:0] n_eff_h;
    logic             in_acc;
    logic             rd_en;
    logic             wr_en;
    logic             pending_full;
    logic             s1_emit;
    logic             s1_adv;
    logic             out_free;
    logic [CW-1:0]    col_inc;
    logic [AW-1:0]    n_col;
    t_win             n_win;
    logic             win_peak;
    logic             interior;
    logic             frame_last;
    logic [PW-1:0]    n_pending;
    logic [AW-1:0]    n_ecol;
    logic [ROW_W-1:0] n_erow;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    // Register read-back.
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_PEAK_THRESHOLD: prdata = DATA_W'(r_thresh);
            REG_IMAGE_WIDTH:    prdata = DATA_W'(r_width);
            REG_IMAGE_HEIGHT:   prdata = DATA_W'(r_height);
            default:            prdata = '0;
        endcase
    end

    // Saturated frame size for a register write.
    always_comb begin
        if (pwdata[WIDTH_W-1:0] < WIDTH_MIN) begin
            n_eff_w = CW'(3);
        end else if (32'(pwdata[WIDTH_W-1:0]) > 32'(MAX_WIDTH)) begin
            n_eff_w = CW'(MAX_WIDTH);
        end else begin
            n_eff_w = CW'(pwdata[WIDTH_W-1:0]);
        end
        if (pwdata[HEIGHT_W-1:0] < HEIGHT_MIN) begin
            n_eff_h = HEIGHT_MIN;
        end else if (pwdata[HEIGHT_W-1:0] > HEIGHT_MAX) begin
            n_eff_h = HEIGHT_MAX;
        end else begin
            n_eff_h = pwdata[HEIGHT_W-1:0];
        end
    end

    // Handshake. The evaluation stage holds only when it has a result and
    // the output register is still occupied.
    assign pending_full = r_pending > PW'(r_eff_w);
    assign s1_emit      = r_s1_valid &&
                          ((r_s1_cmd == CMD_PIXEL) ? pending_full : (r_pending != '0));
    assign out_free     = !r_out_valid || !i_out_stall;
    assign s1_adv       = r_s1_valid && (!s1_emit || out_free);
    assign o_in_stall   = r_s1_valid && !s1_adv;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign rd_en        = in_acc && (i_cmd == CMD_PIXEL);
    assign wr_en        = s1_adv && (r_s1_cmd == CMD_PIXEL);

    // Column address for the next pixel.
    assign col_inc = CW'(r_col) + CW'(1);
    assign n_col   = (col_inc >= r_eff_w) ? '0 : AW'(col_inc);

    // Shifted window and the peak test on its center.
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_up_rd;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_mid_rd;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_px;
        win_peak = n_win[WIN_CTR] > r_thresh;
        for (int k = 0; k < WIN_SIZE; k++) begin
            if (k != WIN_CTR && n_win[k] > n_win[WIN_CTR]) begin
                win_peak = 1'b0;
            end
        end
    end

    // Position of the pixel being reported.
    assign interior   = (r_erow != '0) && (r_erow <= r_hm2) &&
                        (r_ecol != '0) && (CW'(r_ecol) <= r_wm2);
    assign frame_last = (CW'(r_ecol) == r_wm1) && (r_erow == r_hm1);

    always_comb begin
        n_pending = r_pending;
        if (r_s1_cmd == CMD_PIXEL) begin
            if (!pending_full) begin
                n_pending = r_pending + PW'(1);
            end
        end else if (r_pending != '0) begin
            n_pending = r_pending - PW'(1);
        end
        if (frame_last) begin
            n_ecol = '0;
            n_erow = '0;
        end else if (CW'(r_ecol) == r_wm1) begin
            n_ecol = '0;
            n_erow = r_erow + ROW_W'(1);
        end else begin
            n_ecol = r_ecol + AW'(1);
            n_erow = r_erow;
        end
    end

    // Line buffers. A column is written when the evaluation stage advances,
    // after its read, and the next access to that column is at least a row
    // away, so reads never see a write in flight.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_up[r_s1_addr] <= r_mid_rd;
        end
        if (rd_en) begin
            r_up_rd <= r_line_up[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mid[r_s1_addr] <= r_s1_px;
        end
        if (rd_en) begin
            r_mid_rd <= r_line_mid[r_col];
        end
    end

    // Evaluation stage payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_cmd;
            r_s1_px   <= i_pixel_value;
            r_s1_addr <= r_col;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emit) begin
            r_out_peak <= (r_s1_cmd == CMD_PIXEL) && interior && win_peak;
            r_out_last <= frame_last;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RST;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_eff_w     <= EFF_W_RST;
            r_wm1       <= WM1_RST;
            r_wm2       <= WM2_RST;
            r_hm1       <= HM1_RST;
            r_hm2       <= HM2_RST;
            r_col       <= '0;
            r_pending   <= '0;
            r_ecol      <= '0;
            r_erow      <= '0;
            r_win       <= '{default: '0};
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                if (i_cmd == CMD_PIXEL) begin
                    r_col <= n_col;
                end
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_pending <= n_pending;
                if (r_s1_cmd == CMD_PIXEL) begin
                    r_win <= n_win;
                end
                if (s1_emit) begin
                    r_ecol <= n_ecol;
                    r_erow <= n_erow;
                end
            end

            if (s1_adv && s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // A size change restarts the frame; line buffers keep their data.
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_PEAK_THRESHOLD: begin
                        r_thresh <= pwdata[THRESH_W-1:0];
                    end
                    REG_IMAGE_WIDTH: begin
                        r_width   <= pwdata[WIDTH_W-1:0];
                        r_eff_w   <= n_eff_w;
                        r_wm1     <= n_eff_w - CW'(1);
                        r_wm2     <= n_eff_w - CW'(2);
                        r_col     <= '0;
                        r_pending <= '0;
                        r_ecol    <= '0;
                        r_erow    <= '0;
                        r_win     <= '{default: '0};
                    end
                    REG_IMAGE_HEIGHT: begin
                        r_height  <= pwdata[HEIGHT_W-1:0];
                        r_hm1     <= ROW_W'(n_eff_h - HEIGHT_W'(1));
                        r_hm2     <= ROW_W'(n_eff_h - HEIGHT_W'(2));
                        r_col     <= '0;
                        r_pending <= '0;
                        r_ecol    <= '0;
                        r_erow    <= '0;
                        r_win     <= '{default: '0};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_peak    = r_out_peak;
    assign o_frame_last = r_out_last;

    // The input side only stalls while a result is waiting in the stage.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_emit && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // No more than one row plus one pixel may be outstanding.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PW'(r_eff_w) + PW'(1))
        else $error("pending count beyond one row plus one pixel");

    // Report position stays inside the configured row.
    a_ecol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_ecol) < r_eff_w)
        else $error("report column outside the image width");

    // A result leaves the output register only when the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_last)))
        else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// File: sim/tb_local_max_suppress_3x3.sv
// Self-checking testbench for local_max_suppress_3x3: drives pixel and flush transactions,
// predicts each result from an in-bench window model and compares it in raster order.
// Depends on lms_pkg and local_max_suppress_3x3 only.
`timescale 1ns / 1ps

module tb_local_max_suppress_3x3;

    import lms_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int REG_UNUSED_IDX = 3;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;

    typedef enum int {PIX_UNIFORM, PIX_LEVELS, PIX_NEAR_THR} t_pix_mode;

    typedef struct packed {
        logic is_peak;
        logic frame_last;
    } t_mark;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_cmd;
    t_pixel            i_pixel_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_is_peak;
    logic              o_frame_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor state: registers, the two stored rows, the 3x3 window and positions.
    logic [THRESH_W-1:0] thr_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_pixel              row_above [MAX_W];
    t_pixel              row_prev [MAX_W];
    t_pixel              win_px [WIN_SIZE];
    int                  next_col;
    int                  report_idx;
    int                  backlog;

    t_mark peak_queue [$];
    int    mismatch_count = 0;
    int    items_sent = 0;
    int    hold_left = 0;
    bit    src_idle_on = 1'b1;
    bit    rx_idle_on = 1'b1;
    event  hold_start;

    local_max_suppress_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_pixel_value(i_pixel_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_is_peak    (o_is_peak),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("local_max_suppress_3x3 verification failed");
        $finish;
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // ---------------- predictor ----------------

    function automatic int active_width();
        int w;
        w = width_reg;
        if (w < WIDTH_MIN) w = WIDTH_MIN;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = height_reg;
        if (h < HEIGHT_MIN) h = HEIGHT_MIN;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    task automatic restart_stream();
        for (int i = 0; i < WIN_SIZE; i++) win_px[i] = '0;
        next_col   = 0;
        report_idx = 0;
        backlog    = 0;
    endtask

    task automatic model_reset();
        thr_reg    = THRESH_RST;
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        for (int i = 0; i < MAX_W; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        restart_stream();
    endtask

    task automatic model_reg_write(input int idx, input logic [DATA_W-1:0] value);
        case (idx)
            REG_PEAK_THRESHOLD: thr_reg = value[THRESH_W-1:0];
            REG_IMAGE_WIDTH: begin
                width_reg = value[WIDTH_W-1:0];
                restart_stream();
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = value[HEIGHT_W-1:0];
                restart_stream();
            end
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] reg_expected(input int idx);
        case (idx)
            REG_PEAK_THRESHOLD: return DATA_W'(thr_reg);
            REG_IMAGE_WIDTH:    return DATA_W'(width_reg);
            default:            return DATA_W'(height_reg);
        endcase
    endfunction

    function automatic logic window_is_peak();
        logic pk;
        pk = (win_px[WIN_CTR] > thr_reg);
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (i != WIN_CTR && win_px[i] > win_px[WIN_CTR]) pk = 1'b0;
        end
        return pk;
    endfunction

    // Border positions are never marked, whatever the window says.
    task automatic report_pixel(input logic pk);
        int    w, h, er, ec;
        t_mark m;
        w = active_width();
        h = active_height();
        er = report_idx / w;
        ec = report_idx % w;
        m.frame_last = (report_idx == w * h - 1);
        m.is_peak = pk && er >= 1 && er <= h - 2 && ec >= 1 && ec <= w - 2;
        peak_queue.insert(peak_queue.size(), m);
        report_idx = m.frame_last ? 0 : report_idx + 1;
        backlog--;
    endtask

    task automatic predict_item(input logic cmd, input t_pixel px);
        int     w, c;
        t_pixel up, mid;
        w = active_width();
        if (cmd == CMD_PIXEL) begin
            c = next_col;
            if (c >= w) c = 0;
            up = row_above[c];
            mid = row_prev[c];
            row_above[c] = mid;
            row_prev[c] = px;
            for (int r = 0; r < 3; r++) begin
                win_px[r*3]   = win_px[r*3+1];
                win_px[r*3+1] = win_px[r*3+2];
            end
            win_px[2] = up;
            win_px[5] = mid;
            win_px[8] = px;
            next_col = c + 1;
            if (next_col >= w) next_col = 0;
            backlog++;
            if (backlog > w + 1) report_pixel(window_is_peak());
        end else if (backlog != 0) begin
            report_pixel(1'b0);
        end
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_mark want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (peak_queue.size() == 0) begin
                note_failure($sformatf("unexpected result is_peak=%0b frame_last=%0b",
                                       o_is_peak, o_frame_last));
            end else begin
                want = peak_queue.pop_front();
                if (o_is_peak !== want.is_peak || o_frame_last !== want.frame_last) begin
                    note_failure($sformatf(
                        "result mismatch: expected is_peak=%0b frame_last=%0b, got %0b %0b",
                        want.is_peak, want.frame_last, o_is_peak, o_frame_last));
                end
            end
        end
    end

    // Receiver: random stall after each transaction, plus a long hold-off on request.
    initial begin
        int  stall_left;
        bit  hold_now;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                stall_left = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            hold_now = (hold_left > 0);
            @(negedge i_clk);
            if (hold_now) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Counts down the long receiver hold-off once a test starts it.
    initial begin
        forever begin
            @(hold_start);
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
                @(negedge i_clk);
                hold_left--;
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(input logic cmd, input t_pixel px);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_pixel_value <= px;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(cmd, px);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_pixel draw_pixel(input t_pix_mode mode);
        int v;
        case (mode)
            PIX_UNIFORM: v = $urandom_range(0, 255);
            // A handful of levels gives plenty of ties between neighbours.
            PIX_LEVELS: v = $urandom_range(0, 3) * 85;
            default: begin
                v = int'(thr_reg) + $urandom_range(0, 2) - 1;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
        endcase
        return t_pixel'(v);
    endfunction

    task automatic send_pixels(input int count, input t_pix_mode mode, input int flush_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < flush_pct) send_item(CMD_FLUSH, t_pixel'($urandom));
            else send_item(CMD_PIXEL, draw_pixel(mode));
        end
    endtask

    task automatic send_flushes(input int count);
        repeat (count) send_item(CMD_FLUSH, t_pixel'($urandom));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (peak_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_read_check(input int idx);
        logic [DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== reg_expected(idx)) begin
            note_failure($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                                   idx, reg_expected(idx), got));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reg_write(input int idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_reg_write(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        if (idx <= REG_IMAGE_HEIGHT) reg_read_check(idx);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_values();
        for (int i = REG_PEAK_THRESHOLD; i <= REG_IMAGE_HEIGHT; i++) reg_read_check(i);
    endtask

    // A flush, then a 4x4 frame: a tied peak just above threshold, values equal to the
    // threshold, full-scale pixels on the border, then flushes past the end of the frame.
    task automatic test_directed_frame();
        t_pixel img [16];
        img = '{8'd0,   8'd51, 8'd0,  8'd255,
                8'd0,   8'd51, 8'd50, 8'd0,
                8'd0,   8'd50, 8'd7,  8'd255,
                8'd255, 8'd0,  8'd0,  8'd255};
        reg_write(REG_PEAK_THRESHOLD, 50);
        reg_write(REG_IMAGE_WIDTH, 4);
        reg_write(REG_IMAGE_HEIGHT, 4);
        send_item(CMD_FLUSH, 8'hff);
        for (int i = 0; i < 16; i++) send_item(CMD_PIXEL, img[i]);
        send_flushes(6);
        wait_idle();
    endtask

    task automatic test_unused_register();
        reg_write(REG_UNUSED_IDX, $urandom);
        for (int i = REG_PEAK_THRESHOLD; i <= REG_IMAGE_HEIGHT; i++) reg_read_check(i);
        send_pixels(20, PIX_LEVELS, 0);
        send_flushes(5);
        wait_idle();
    endtask

    task automatic test_threshold_extremes();
        reg_write(REG_IMAGE_WIDTH, 5);
        reg_write(REG_IMAGE_HEIGHT, 4);
        reg_write(REG_PEAK_THRESHOLD, 0);
        send_pixels(20, PIX_LEVELS, 0);
        send_pixels(20, PIX_NEAR_THR, 0);
        send_flushes(6);
        wait_idle();
        reg_write(REG_PEAK_THRESHOLD, 255);
        send_pixels(20, PIX_LEVELS, 0);
        send_flushes(6);
        wait_idle();
    endtask

    task automatic test_size_limits();
        reg_write(REG_PEAK_THRESHOLD, $urandom_range(0, 120));
        reg_write(REG_IMAGE_WIDTH, 0);
        reg_write(REG_IMAGE_HEIGHT, 2);
        send_pixels(9, PIX_UNIFORM, 0);
        send_flushes(4);
        wait_idle();
        reg_write(REG_IMAGE_WIDTH, 2);
        reg_write(REG_IMAGE_HEIGHT, 1);
        send_pixels(9, PIX_LEVELS, 0);
        send_flushes(5);
        wait_idle();
        reg_write(REG_IMAGE_WIDTH, 3);
        reg_write(REG_IMAGE_HEIGHT, 4096);
        send_pixels(40, PIX_UNIFORM, 0);
        wait_idle();
        reg_write(REG_IMAGE_HEIGHT, 8191);
        send_pixels(40, PIX_LEVELS, 0);
        wait_idle();
        reg_write(REG_IMAGE_WIDTH, 1024);
        reg_write(REG_IMAGE_WIDTH, 2047);
        reg_write(REG_IMAGE_HEIGHT, 0);
        send_pixels(1030, PIX_UNIFORM, 0);
        send_flushes(3);
        wait_idle();
    endtask

    task automatic test_random_frames(input int count);
        int        target, w, h, frames, flush_pct;
        t_pix_mode mode;
        target = items_sent + count;
        while (items_sent < target) begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 4))
                0:       reg_write(REG_PEAK_THRESHOLD, 0);
                1:       reg_write(REG_PEAK_THRESHOLD, 255);
                default: reg_write(REG_PEAK_THRESHOLD, $urandom_range(0, 255));
            endcase
            // Sometimes keep the size so the stream carries on from the previous phase.
            if ($urandom_range(0, 3) == 0 && active_width() * active_height() <= 400) begin
                w = active_width();
                h = active_height();
            end else begin
                w = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
                h = $urandom_range(3, 7);
                reg_write(REG_IMAGE_WIDTH, w);
                reg_write(REG_IMAGE_HEIGHT, h);
            end
            frames = $urandom_range(1, 3);
            flush_pct = ($urandom_range(0, 5) == 0) ? 5 : 0;
            repeat (frames) begin
                mode = t_pix_mode'($urandom_range(0, 2));
                send_pixels(w * h, mode, flush_pct);
            end
            if ($urandom_range(0, 3) != 0) send_flushes(w + 1 + $urandom_range(0, 2));
            wait_idle();
        end
        src_idle_on = 1'b1;
        rx_idle_on  = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering back-to-back transactions.
    task automatic test_stall_pressure();
        reg_write(REG_PEAK_THRESHOLD, 50);
        reg_write(REG_IMAGE_WIDTH, 8);
        reg_write(REG_IMAGE_HEIGHT, 6);
        src_idle_on = 1'b0;
        -> hold_start;
        send_pixels(48, PIX_UNIFORM, 0);
        send_flushes(9);
        src_idle_on = 1'b1;
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_PIXEL;
        i_pixel_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        model_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed_frame();
        test_unused_register();
        test_threshold_extremes();
        test_size_limits();
        test_random_frames(50);
        test_stall_pressure();

        wait_idle();
        if (mismatch_count == 0 && peak_queue.size() == 0) begin
            $display("local_max_suppress_3x3 verification clean");
        end else begin
            $display("local_max_suppress_3x3 verification failed");
        end
        $finish;
    end

endmodule

// File: local_max_suppress_3x3.f
src/lms_pkg.sv
src/local_max_suppress_3x3.sv
sim/tb_local_max_suppress_3x3.sv
